// File: src/psc_pkg.sv
// psc_pkg: shared constants, types and codes for the clamped pid step block
`timescale 1ns / 1ps

package psc_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int GAIN_W        = 16;
    localparam int GAIN_FRAC     = 8;
    localparam int OUTPUT_LIMIT  = 255;
    localparam int INTEG_LIMIT   = 255;
    localparam int INTEG_W       = 32;
    localparam int ERR_W         = SAMPLE_W + 1;
    localparam int DERR_W        = SAMPLE_W + 2;
    localparam int DRIVE_W       = 9;
    localparam int IN_TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((DRIVE_W + 7) / 8) * 8;
    localparam int CFG_IDX_W     = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KI = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KD = CFG_IDX_W'(2);

    // item kinds
    localparam logic OP_MEASUREMENT = 1'b0;
    localparam logic OP_SETPOINT    = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [GAIN_W-1:0]   t_gain;
    typedef logic signed [ERR_W-1:0]    t_err;
    typedef logic signed [DERR_W-1:0]   t_derr;
    typedef logic signed [INTEG_W-1:0]  t_integ;
    typedef logic signed [DRIVE_W-1:0]  t_drive;

    // one step's operands, handed from the front to the back
    typedef struct packed {
        t_derr  derr;
        t_integ sum;
        t_err   err;
    } t_step;

    typedef struct packed {
        t_gain kp;
        t_gain ki;
        t_gain kd;
    } t_gains;

endpackage

// File: src/psc_front.sv
// psc_front: takes items, updates setpoint, measurement, integral and last error
`timescale 1ns / 1ps

module psc_front import psc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic    i_opcode,
    input  t_sample i_sample,
    input  logic    i_full,
    output logic    o_push,
    output t_step   o_step
);

    t_sample r_setpoint, n_setpoint;
    t_sample r_measure, n_measure;
    t_integ  r_integral, n_integral;
    t_err    r_prev_err;

    t_err                       w_err;
    t_derr                      w_derr;
    logic signed [INTEG_W:0]    w_sum_wide;
    t_integ                     w_sum;
    logic                       w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept;

    always_comb begin
        n_setpoint = r_setpoint;
        n_measure  = r_measure;
        if (i_opcode == OP_SETPOINT) begin
            n_setpoint = i_sample;
        end else begin
            n_measure = i_sample;
        end
        w_err      = ERR_W'(n_setpoint) - ERR_W'(n_measure);
        w_sum_wide = (INTEG_W + 1)'(r_integral) + (INTEG_W + 1)'(w_err);
        // saturate to the 32-bit range
        if (w_sum_wide[INTEG_W] != w_sum_wide[INTEG_W-1]) begin
            w_sum = w_sum_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            w_sum = w_sum_wide[INTEG_W-1:0];
        end
        n_integral = (w_sum > $signed(INTEG_W'(INTEG_LIMIT))) ? '0 : w_sum;
        w_derr     = DERR_W'(w_err) - DERR_W'(r_prev_err);
    end

    assign o_step.err  = w_err;
    assign o_step.sum  = w_sum;
    assign o_step.derr = w_derr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_measure  <= '0;
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (w_accept) begin
            r_setpoint <= n_setpoint;
            r_measure  <= n_measure;
            r_integral <= n_integral;
            r_prev_err <= w_err;
        end
    end

`ifndef SYNTHESIS
    a_integral_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integral <= $signed(INTEG_W'(INTEG_LIMIT)))
        else $error("integral above limit");
    a_prev_err_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_prev_err == $past(w_err))
        else $error("last error not kept");
`endif

endmodule

// File: src/psc_queue.sv
// psc_queue: short queue of step operands between front and back
`timescale 1ns / 1ps

module psc_queue import psc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_step i_data,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_ready,
    output t_step o_data
);

    t_step             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= (r_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// File: src/psc_back.sv
// psc_back: gain products, sum, truncation toward zero and clamp to the drive range
`timescale 1ns / 1ps

module psc_back import psc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_step  i_step,
    input  t_gains i_gains,
    output logic   o_valid,
    input  logic   i_ready,
    output t_drive o_drive
);

    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + INTEG_W;
    localparam int PROD_D_W = GAIN_W + DERR_W;
    localparam int ACC_W    = PROD_I_W + 1;
    localparam int QUOT_W   = ACC_W - GAIN_FRAC;
    localparam logic signed [QUOT_W-1:0] Q_MAX = QUOT_W'(OUTPUT_LIMIT);
    localparam logic signed [QUOT_W-1:0] Q_MIN = -Q_MAX;

    logic                       r_v1, r_v2, r_vo;
    logic                       w_en1, w_en2, w_eno;
    logic signed [PROD_P_W-1:0] r_prod_p;
    logic signed [PROD_I_W-1:0] r_prod_i;
    logic signed [PROD_D_W-1:0] r_prod_d;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    w_biased;
    logic signed [QUOT_W-1:0]   w_quot;
    t_drive                     r_drive, n_drive;

    assign w_eno   = !r_vo || i_ready;
    assign w_en2   = !r_v2 || w_eno;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_vo;
    assign o_drive = r_drive;

    always_comb begin
        // round toward zero: bias negative sums before the shift
        w_biased = r_acc + (r_acc[ACC_W-1] ? ACC_W'((1 << GAIN_FRAC) - 1) : ACC_W'(0));
        w_quot   = w_biased[ACC_W-1:GAIN_FRAC];
        if (w_quot > Q_MAX) begin
            n_drive = DRIVE_W'(OUTPUT_LIMIT);
        end else if (w_quot < Q_MIN) begin
            n_drive = -DRIVE_W'(OUTPUT_LIMIT);
        end else begin
            n_drive = w_quot[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_prod_p <= PROD_P_W'(i_gains.kp) * PROD_P_W'(i_step.err);
            r_prod_i <= PROD_I_W'(i_gains.ki) * PROD_I_W'(i_step.sum);
            r_prod_d <= PROD_D_W'(i_gains.kd) * PROD_D_W'(i_step.derr);
        end
        if (w_en2) begin
            r_acc <= ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
        end
        if (w_eno && r_v2) begin
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_eno) begin
                r_vo <= r_v2;
            end
        end
    end

`ifndef SYNTHESIS
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_drive <= DRIVE_W'(OUTPUT_LIMIT) && r_drive >= -DRIVE_W'(OUTPUT_LIMIT)))
        else $error("drive outside limit");
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_eno) |=> r_v2 && $stable(r_acc))
        else $error("stalled sum stage changed");
`endif

endmodule

// File: src/pid_step_clamped.sv
// pid_step_clamped: top level, gain registers, front, queue and back
//
//  channel   direction  payload
//  s_axis    in         tdata: sample_value[15:0]; tuser: opcode[0]
//  m_axis    out        tdata: drive[8:0], zero fill to 16 bits
//  cfg       in         i_cfg_we, i_cfg_index, i_cfg_data (gain_proportional,
//                       gain_integral, gain_derivative)
//
//  one item per cycle unless the output stalls; each item gives one result
//  output valid follows the queue write on the transfer edge, then the
//  product, sum and clamp stages of the back
//  a four-entry queue lets input go on while the output stalls, until full
//  sync active-low reset clears front regs, queue pointers, gains, valid bits
`timescale 1ns / 1ps

module pid_step_clamped import psc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_value
    input  logic                   s_axis_tuser,   // opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // drive, zero fill above
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]      i_cfg_data
);

    t_gains r_gains;
    logic   w_push, w_full, w_q_valid, w_q_ready;
    t_step  w_step_in, w_step_out;
    t_drive w_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KP:  r_gains.kp <= $signed(i_cfg_data);
                REG_KI:  r_gains.ki <= $signed(i_cfg_data);
                REG_KD:  r_gains.kd <= $signed(i_cfg_data);
                default: r_gains    <= r_gains;
            endcase
        end
    end

    psc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_opcode (s_axis_tuser),
        .i_sample ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_step   (w_step_in)
    );

    psc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_step_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_step_out)
    );

    psc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_step  (w_step_out),
        .i_gains (r_gains),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_drive (w_drive)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-DRIVE_W){1'b0}}, w_drive};

endmodule
